### sv/nec_ir_pulse_decoder_defines.svh
// assertion macros for the decoder modules, used by nip_frame
// no dependencies; included by the files that carry assertions
`ifndef NEC_IR_PULSE_DECODER_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NIP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// next-cycle implication, checked outside reset
`define NIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

### sv/nip_pkg.sv
// shared types and constants of the ir pulse decoder
// no dependencies; used by nip_classify, nip_frame and the top level
package nip_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_ADDR_MARK  = 3'd3,
    ST_ADDR_SPACE = 3'd4,
    ST_CMD_MARK   = 3'd5,
    ST_CMD_SPACE  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    REG_HDR_MARK_MIN  = 4'd0,
    REG_HDR_MARK_MAX  = 4'd1,
    REG_HDR_SPACE_MIN = 4'd2,
    REG_HDR_SPACE_MAX = 4'd3,
    REG_SHORT_MIN     = 4'd4,
    REG_SHORT_MAX     = 4'd5,
    REG_LONG_MIN      = 4'd6,
    REG_LONG_MAX      = 4'd7
  } reg_index_t;

  localparam int unsigned TICK_W = 15;
  localparam int unsigned US_W   = 16;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned POS_W  = 6;

  localparam logic [POS_W-1:0] POS_HEADER    = 6'd0;
  localparam logic [POS_W-1:0] POS_LAST_ADDR = 6'd16;
  localparam logic [POS_W-1:0] POS_END_ITEM  = 6'd33;
  localparam logic [POS_W-1:0] POS_WAIT      = 6'd34;

  localparam logic [US_W-1:0] RST_HDR_MARK_MIN  = 16'd8800;
  localparam logic [US_W-1:0] RST_HDR_MARK_MAX  = 16'd9200;
  localparam logic [US_W-1:0] RST_HDR_SPACE_MIN = 16'd4300;
  localparam logic [US_W-1:0] RST_HDR_SPACE_MAX = 16'd4700;
  localparam logic [US_W-1:0] RST_SHORT_MIN     = 16'd460;
  localparam logic [US_W-1:0] RST_SHORT_MAX     = 16'd660;
  localparam logic [US_W-1:0] RST_LONG_MIN      = 16'd1590;
  localparam logic [US_W-1:0] RST_LONG_MAX      = 16'd1790;

  typedef struct packed {
    logic [US_W-1:0] hdr_mark_min;
    logic [US_W-1:0] hdr_mark_max;
    logic [US_W-1:0] hdr_space_min;
    logic [US_W-1:0] hdr_space_max;
    logic [US_W-1:0] short_min;
    logic [US_W-1:0] short_max;
    logic [US_W-1:0] long_min;
    logic [US_W-1:0] long_max;
  } limits_t;

  typedef struct packed {
    logic header_ok;
    logic mark_ok;
    logic space_ok;
    logic bit_val;
  } class_t;

endpackage

### sv/nip_classify.sv
// converts a pulse pair to microseconds and checks it against the windows
// depends on nip_pkg
module nip_classify (
  input  nip_pkg::limits_t              limits,
  input  logic [nip_pkg::TICK_W-1:0]    mark_ticks,
  input  logic [nip_pkg::TICK_W-1:0]    space_ticks,
  output nip_pkg::class_t               cls
);

  logic [nip_pkg::TICK_W+2:0] mark_x5;
  logic [nip_pkg::TICK_W+2:0] space_x5;
  logic [nip_pkg::US_W-1:0]   mark_us;
  logic [nip_pkg::US_W-1:0]   space_us;
  logic                       zero_ok;
  logic                       one_ok;

  // ticks * 5 / 4
  assign mark_x5  = {3'b000, mark_ticks} + {1'b0, mark_ticks, 2'b00};
  assign space_x5 = {3'b000, space_ticks} + {1'b0, space_ticks, 2'b00};
  assign mark_us  = mark_x5[nip_pkg::TICK_W+2:2];
  assign space_us = space_x5[nip_pkg::TICK_W+2:2];

  assign zero_ok = (space_us > limits.short_min) && (space_us < limits.short_max);
  assign one_ok  = (space_us > limits.long_min) && (space_us < limits.long_max);

  always_comb begin
    cls.header_ok = (mark_us >= limits.hdr_mark_min) && (mark_us <= limits.hdr_mark_max)
                 && (space_us >= limits.hdr_space_min)
                 && (space_us <= limits.hdr_space_max);
    cls.mark_ok   = (mark_us >= limits.short_min) && (mark_us <= limits.short_max);
    cls.space_ok  = zero_ok || one_ok;
    cls.bit_val   = !zero_ok;
  end

endmodule

### sv/nip_frame.sv
// frame sequencer: position, bit shift registers, error hold and result register
// depends on nip_pkg and nec_ir_pulse_decoder_defines.svh
`include "nec_ir_pulse_decoder_defines.svh"

module nip_frame (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  nip_pkg::class_t               cls,
  input  logic                          buffer_end,
  input  logic                          out_ready,
  output logic                          out_free,
  output logic                          out_valid,
  output nip_pkg::status_t              out_status,
  output logic [nip_pkg::WORD_W-1:0]    out_address,
  output logic [nip_pkg::WORD_W-1:0]    out_command
);

  logic [nip_pkg::POS_W-1:0]  pos, pos_next;
  logic [nip_pkg::WORD_W-1:0] addr_shift, addr_shift_next;
  logic [nip_pkg::WORD_W-1:0] cmd_shift, cmd_shift_next;
  nip_pkg::status_t           pending, pending_next;
  logic                       skip, skip_next;
  logic                       emit;
  nip_pkg::status_t           emit_status;
  logic [nip_pkg::WORD_W-1:0] emit_address;
  logic [nip_pkg::WORD_W-1:0] emit_command;
  logic                       is_addr;

  assign out_free = !out_valid || out_ready;
  assign is_addr  = (pos <= nip_pkg::POS_LAST_ADDR);

  always_comb begin
    pos_next        = pos;
    addr_shift_next = addr_shift;
    cmd_shift_next  = cmd_shift;
    pending_next    = pending;
    skip_next       = skip;
    emit            = 1'b0;
    emit_status     = nip_pkg::ST_OK;
    emit_address    = '0;
    emit_command    = '0;
    if (step) begin
      if (pos >= nip_pkg::POS_WAIT) begin
        if (buffer_end) begin
          pos_next  = nip_pkg::POS_HEADER;
          pending_next = nip_pkg::ST_OK;
          skip_next = 1'b0;
          addr_shift_next = '0;
          cmd_shift_next  = '0;
        end
      end else if (pos < nip_pkg::POS_END_ITEM) begin
        if (!skip) begin
          if (pos == nip_pkg::POS_HEADER) begin
            if (!cls.header_ok) begin
              pending_next = nip_pkg::ST_BAD_HEADER;
              skip_next    = 1'b1;
            end
          end else if (!cls.mark_ok) begin
            pending_next = is_addr ? nip_pkg::ST_ADDR_MARK : nip_pkg::ST_CMD_MARK;
            skip_next    = 1'b1;
          end else if (!cls.space_ok) begin
            pending_next = is_addr ? nip_pkg::ST_ADDR_SPACE : nip_pkg::ST_CMD_SPACE;
            skip_next    = 1'b1;
          end else if (is_addr) begin
            addr_shift_next = {cls.bit_val, addr_shift[nip_pkg::WORD_W-1:1]};
          end else begin
            cmd_shift_next = {cls.bit_val, cmd_shift[nip_pkg::WORD_W-1:1]};
          end
        end
        pos_next = pos + nip_pkg::POS_W'(1);
        if (buffer_end) begin
          emit            = 1'b1;
          emit_status     = nip_pkg::ST_TOO_SHORT;
          pos_next        = nip_pkg::POS_HEADER;
          pending_next    = nip_pkg::ST_OK;
          skip_next       = 1'b0;
          addr_shift_next = '0;
          cmd_shift_next  = '0;
        end
      end else begin
        // end item: verdict
        emit = 1'b1;
        if (skip) begin
          emit_status = pending;
          if (buffer_end) begin
            pos_next     = nip_pkg::POS_HEADER;
            pending_next = nip_pkg::ST_OK;
            skip_next    = 1'b0;
            addr_shift_next = '0;
            cmd_shift_next  = '0;
          end else begin
            pos_next = nip_pkg::POS_WAIT;
          end
        end else begin
          emit_status     = nip_pkg::ST_OK;
          emit_address    = addr_shift;
          emit_command    = cmd_shift;
          pos_next        = nip_pkg::POS_HEADER;
          addr_shift_next = '0;
          cmd_shift_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= nip_pkg::POS_HEADER;
      addr_shift <= '0;
      cmd_shift  <= '0;
      pending    <= nip_pkg::ST_OK;
      skip       <= 1'b0;
    end else begin
      pos        <= pos_next;
      addr_shift <= addr_shift_next;
      cmd_shift  <= cmd_shift_next;
      pending    <= pending_next;
      skip       <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status  <= emit_status;
      out_address <= emit_address;
      out_command <= emit_command;
    end
  end

  `NIP_ASSERT_NOW(a_pos_range, clk, rst, 1'b1, pos <= nip_pkg::POS_WAIT)
  `NIP_ASSERT_NOW(a_wait_after_error, clk, rst, pos == nip_pkg::POS_WAIT, skip)
  `NIP_ASSERT_NOW(a_skip_has_error, clk, rst, skip, pending != nip_pkg::ST_OK)
  `NIP_ASSERT_NOW(a_error_fields_zero, clk, rst,
    out_valid && out_status != nip_pkg::ST_OK, out_address == '0 && out_command == '0)
  `NIP_ASSERT_NEXT(a_verdict_emits, clk, rst,
    step && pos == nip_pkg::POS_END_ITEM, out_valid)

endmodule

### sv/nec_ir_pulse_decoder.sv
// Decoder for infrared remote frames in the NEC format. Each transfer on the
// input carries one captured mark/space pair in 1.25 us ticks and tlast on
// the last pair of a receive buffer; a frame is a header pair, 32 bit pairs
// and an end pair, and the verdict (status, address, command) leaves as one
// output transfer when the end pair arrives, or as "too short" when the
// buffer ends first. One pair is taken every clock cycle; a pair is held in
// an input register, and its result passes from there through one level of
// compare logic into the result register. The input side stalls while a pair
// sits in the input register and a result waits unaccepted in the result
// register.
// depends on nip_pkg, nip_classify and nip_frame
module nec_ir_pulse_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // mark_ticks[14:0], space_ticks[29:15], zero pad
  input  logic        s_tlast,   // buffer_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[2:0], address[18:3], command[34:19], zero pad
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  nip_pkg::limits_t               limits;
  logic                           in_valid;
  logic [nip_pkg::TICK_W-1:0]     in_mark;
  logic [nip_pkg::TICK_W-1:0]     in_space;
  logic                           in_end;
  logic                           advance;
  logic                           out_free;
  nip_pkg::class_t                cls;
  nip_pkg::status_t               out_status;
  logic [nip_pkg::WORD_W-1:0]     out_address;
  logic [nip_pkg::WORD_W-1:0]     out_command;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.hdr_mark_min  <= nip_pkg::RST_HDR_MARK_MIN;
      limits.hdr_mark_max  <= nip_pkg::RST_HDR_MARK_MAX;
      limits.hdr_space_min <= nip_pkg::RST_HDR_SPACE_MIN;
      limits.hdr_space_max <= nip_pkg::RST_HDR_SPACE_MAX;
      limits.short_min     <= nip_pkg::RST_SHORT_MIN;
      limits.short_max     <= nip_pkg::RST_SHORT_MAX;
      limits.long_min      <= nip_pkg::RST_LONG_MIN;
      limits.long_max      <= nip_pkg::RST_LONG_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        nip_pkg::REG_HDR_MARK_MIN:  limits.hdr_mark_min  <= cfg_data;
        nip_pkg::REG_HDR_MARK_MAX:  limits.hdr_mark_max  <= cfg_data;
        nip_pkg::REG_HDR_SPACE_MIN: limits.hdr_space_min <= cfg_data;
        nip_pkg::REG_HDR_SPACE_MAX: limits.hdr_space_max <= cfg_data;
        nip_pkg::REG_SHORT_MIN:     limits.short_min     <= cfg_data;
        nip_pkg::REG_SHORT_MAX:     limits.short_max     <= cfg_data;
        nip_pkg::REG_LONG_MIN:      limits.long_min      <= cfg_data;
        nip_pkg::REG_LONG_MAX:      limits.long_max      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mark  <= s_tdata[14:0];
      in_space <= s_tdata[29:15];
      in_end   <= s_tlast;
    end
  end

  nip_classify u_classify (
    .limits      (limits),
    .mark_ticks  (in_mark),
    .space_ticks (in_space),
    .cls         (cls)
  );

  nip_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .cls         (cls),
    .buffer_end  (in_end),
    .out_ready   (m_tready),
    .out_free    (out_free),
    .out_valid   (m_tvalid),
    .out_status  (out_status),
    .out_address (out_address),
    .out_command (out_command)
  );

  assign m_tdata = {5'b00000, out_command, out_address, out_status};

endmodule
